// ----- sv/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL files.
// Each macro checks a property on the rising edge of clk; FXQ_ASSERT is
// disabled while rst_n is low. Synthesis sees empty bodies.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FXQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FXQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FXQ_ASSERT(lbl, prop, msg)
`define FXQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- sv/fxq_pkg.sv -----
// ---------------------------------------------------------------------------
// fxq_pkg
// Operation codes and the side-band bundle of the fixed-point ALU pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fxq_pkg;

  // Operation codes carried in the request type field.
  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_MIN      = 4'd4,
    OP_MAX      = 4'd5,
    OP_INC      = 4'd6,
    OP_DEC      = 4'd7,
    OP_FROM_INT = 4'd8,
    OP_TO_INT   = 4'd9,
    OP_COMPARE  = 4'd10
  } op_t;

  localparam logic [31:0] RAW_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] RAW_MIN = 32'h8000_0000;

  // Everything that travels alongside the divider for one beat.
  typedef struct packed {
    logic [31:0] result;
    logic        less;
    logic        equal;
    logic        greater;
    logic        dz;
    logic        ovf;
    logic        is_div;
    logic        neg;
  } side_t;

endpackage

// ----- sv/fxq_div_pipe.sv -----
// ---------------------------------------------------------------------------
// fxq_div_pipe
// Pipelined restoring divider: one quotient bit per register stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fxq_div_pipe #(
  parameter int NQ = 40
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  logic                 in_valid,
  input  logic [NQ-1:0]        in_num,
  input  logic [31:0]          in_den,
  input  fxq_pkg::side_t       in_side,
  output logic                 out_valid,
  output logic [NQ-1:0]        out_quo,
  output logic [31:0]          out_rem,
  output logic [31:0]          out_den,
  output fxq_pkg::side_t       out_side
);

  logic                vld_r  [NQ];
  logic [31:0]         rem_r  [NQ];
  logic [NQ-1:0]       num_r  [NQ];
  logic [NQ-1:0]       quo_r  [NQ];
  logic [31:0]         den_r  [NQ];
  fxq_pkg::side_t      side_r [NQ];

  for (genvar k = 0; k < NQ; k++) begin : g_stage
    logic                prv_vld;
    logic [31:0]         prv_rem;
    logic [NQ-1:0]       prv_num;
    logic [NQ-1:0]       prv_quo;
    logic [31:0]         prv_den;
    fxq_pkg::side_t      prv_side;
    logic [32:0]         trial;
    logic [32:0]         diff;
    logic                qbit;

    // Select the previous stage, or the pipeline input for the first one.
    if (k == 0) begin : g_first
      assign prv_vld  = in_valid;
      assign prv_rem  = '0;
      assign prv_num  = in_num;
      assign prv_quo  = '0;
      assign prv_den  = in_den;
      assign prv_side = in_side;
    end else begin : g_next
      assign prv_vld  = vld_r[k-1];
      assign prv_rem  = rem_r[k-1];
      assign prv_num  = num_r[k-1];
      assign prv_quo  = quo_r[k-1];
      assign prv_den  = den_r[k-1];
      assign prv_side = side_r[k-1];
    end

    // Shift in the next dividend bit and try one subtraction.
    assign trial = {prv_rem, prv_num[NQ-1]};
    assign diff  = trial - {1'b0, prv_den};
    assign qbit  = (trial >= {1'b0, prv_den});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (advance) begin
        vld_r[k] <= prv_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        rem_r[k]  <= qbit ? diff[31:0] : trial[31:0];
        num_r[k]  <= {prv_num[NQ-2:0], 1'b0};
        quo_r[k]  <= {prv_quo[NQ-2:0], qbit};
        den_r[k]  <= prv_den;
        side_r[k] <= prv_side;
      end
    end
  end

  assign out_valid = vld_r[NQ-1];
  assign out_quo   = quo_r[NQ-1];
  assign out_rem   = rem_r[NQ-1];
  assign out_den   = den_r[NQ-1];
  assign out_side  = side_r[NQ-1];

endmodule

// ----- sv/fixed_point_q24_8_alu.sv -----
// ---------------------------------------------------------------------------
// fixed_point_q24_8_alu
// Pipelined signed fixed-point ALU: add, sub, mul, div, min, max and more.
// ---------------------------------------------------------------------------
// Usage:
// A request beat carries an operation code and two raw signed operands on
// the in_ channel; each request gives exactly one result beat on the out_
// channel with the raw result and the compare flags, in request order.
// The request enters the first of two operand stages at acceptance, then
// passes one divider stage per quotient bit (32 + FRAC_BITS of them) and
// the output register.
// Throughput is one beat per cycle while out_stall does not hold the
// pipeline; every operation goes through the same stages, so the pipelined
// divider sets the latency and nothing else lowers the rate.
// When the receiver stalls while a result is shown, the whole pipeline
// freezes and in_stall is raised; nothing is lost or repeated.
// Reset clears every stage valid bit; the block accepts requests in the
// first cycle after reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fixed_point_q24_8_alu #(
  parameter int FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_req_type,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_result_raw,
  output logic               out_a_less,
  output logic               out_a_equal,
  output logic               out_a_greater,
  output logic               out_divide_by_zero,
  output logic               out_overflow
);

  localparam int NQ = 32 + FRAC_BITS;
  localparam int QW = NQ + 1;

  logic advance;

  // The pipeline moves unless a shown result is being held back.
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  // Stage one: capture the request and the operand magnitudes.
  logic              s1_v_r;
  logic [3:0]        s1_op_r;
  logic signed [31:0] s1_a_r, s1_b_r;
  logic [31:0]       s1_ma_r, s1_mb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (advance) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_op_r <= in_req_type;
      s1_a_r  <= in_operand_a;
      s1_b_r  <= in_operand_b;
      s1_ma_r <= in_operand_a[31] ? (32'd0 - in_operand_a) : in_operand_a;
      s1_mb_r <= in_operand_b[31] ? (32'd0 - in_operand_b) : in_operand_b;
    end
  end

  // Saturate a 33-bit signed sum into 32 bits.
  function automatic logic [32:0] sat33(input logic [32:0] s);
    logic ovf;
    ovf = s[32] ^ s[31];
    if (ovf) begin
      return {1'b1, s[32] ? fxq_pkg::RAW_MIN : fxq_pkg::RAW_MAX};
    end
    return {1'b0, s[31:0]};
  endfunction

  // Simple operations and the compare flags.
  fxq_pkg::side_t s2_side_nxt;
  logic [32:0]    sum_w, dif_w, inc_w, dec_w, sat_w;
  logic           fi_ovf;

  always_comb begin
    sum_w  = {s1_a_r[31], s1_a_r} + {s1_b_r[31], s1_b_r};
    dif_w  = {s1_a_r[31], s1_a_r} - {s1_b_r[31], s1_b_r};
    inc_w  = {s1_a_r[31], s1_a_r} + 33'd1;
    dec_w  = {s1_a_r[31], s1_a_r} - 33'd1;
    fi_ovf = (s1_a_r[31:31-FRAC_BITS] != {(FRAC_BITS+1){s1_a_r[31]}});
    sat_w  = '0;
    s2_side_nxt = '0;
    s2_side_nxt.less    = (s1_a_r < s1_b_r);
    s2_side_nxt.equal   = (s1_a_r == s1_b_r);
    s2_side_nxt.greater = (s1_a_r > s1_b_r);
    s2_side_nxt.neg     = s1_a_r[31] ^ s1_b_r[31];
    case (s1_op_r)
      fxq_pkg::OP_ADD: begin
        sat_w = sat33(sum_w);
        {s2_side_nxt.ovf, s2_side_nxt.result} = sat_w;
      end
      fxq_pkg::OP_SUB: begin
        sat_w = sat33(dif_w);
        {s2_side_nxt.ovf, s2_side_nxt.result} = sat_w;
      end
      fxq_pkg::OP_DIV: begin
        s2_side_nxt.dz     = (s1_b_r == 32'sd0);
        s2_side_nxt.is_div = (s1_b_r != 32'sd0);
      end
      fxq_pkg::OP_MIN: s2_side_nxt.result = (s1_a_r < s1_b_r) ? s1_a_r : s1_b_r;
      fxq_pkg::OP_MAX: s2_side_nxt.result = (s1_a_r > s1_b_r) ? s1_a_r : s1_b_r;
      fxq_pkg::OP_INC: begin
        sat_w = sat33(inc_w);
        {s2_side_nxt.ovf, s2_side_nxt.result} = sat_w;
      end
      fxq_pkg::OP_DEC: begin
        sat_w = sat33(dec_w);
        {s2_side_nxt.ovf, s2_side_nxt.result} = sat_w;
      end
      fxq_pkg::OP_FROM_INT: begin
        s2_side_nxt.ovf = fi_ovf;
        if (fi_ovf) begin
          s2_side_nxt.result = s1_a_r[31] ? fxq_pkg::RAW_MIN : fxq_pkg::RAW_MAX;
        end else begin
          s2_side_nxt.result = {s1_a_r[31-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
        end
      end
      fxq_pkg::OP_TO_INT: s2_side_nxt.result = s1_a_r >>> FRAC_BITS;
      default: s2_side_nxt.result = '0;
    endcase
  end

  // Stage two: side-band, product and divider operands.
  logic           s2_v_r;
  logic           s2_mul_r;
  fxq_pkg::side_t s2_side_r;
  logic [63:0]    s2_prod_r;
  logic [NQ-1:0]  s2_num_r;
  logic [31:0]    s2_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (advance) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_mul_r  <= (s1_op_r == fxq_pkg::OP_MUL);
      s2_side_r <= s2_side_nxt;
      s2_prod_r <= s1_ma_r * s1_mb_r;
      s2_num_r  <= {s1_ma_r, {FRAC_BITS{1'b0}}};
      s2_den_r  <= s1_mb_r;
    end
  end

  // Round and saturate the product before the divider stages.
  fxq_pkg::side_t div_side_in;
  logic [63:0]    pm_w;

  always_comb begin
    pm_w = (s2_prod_r + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    div_side_in = s2_side_r;
    if (s2_mul_r) begin
      if (!s2_side_r.neg && pm_w > 64'h0000_0000_7FFF_FFFF) begin
        div_side_in.ovf    = 1'b1;
        div_side_in.result = fxq_pkg::RAW_MAX;
      end else if (s2_side_r.neg && pm_w > 64'h0000_0000_8000_0000) begin
        div_side_in.ovf    = 1'b1;
        div_side_in.result = fxq_pkg::RAW_MIN;
      end else begin
        div_side_in.result = s2_side_r.neg ? (32'd0 - pm_w[31:0]) : pm_w[31:0];
      end
    end
  end

  logic           dv_valid;
  logic [NQ-1:0]  dv_quo;
  logic [31:0]    dv_rem;
  logic [31:0]    dv_den;
  fxq_pkg::side_t dv_side;

  fxq_div_pipe #(.NQ(NQ)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .in_valid  (s2_v_r),
    .in_num    (s2_num_r),
    .in_den    (s2_den_r),
    .in_side   (div_side_in),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_rem   (dv_rem),
    .out_den   (dv_den),
    .out_side  (dv_side)
  );

  // Round the quotient to nearest, apply the sign and saturate.
  logic [QW-1:0]  qm_w;
  fxq_pkg::side_t fin_w;

  always_comb begin
    qm_w  = {1'b0, dv_quo} + QW'({dv_rem, 1'b0} >= {1'b0, dv_den});
    fin_w = dv_side;
    if (dv_side.is_div) begin
      if (!dv_side.neg && qm_w > QW'(fxq_pkg::RAW_MAX)) begin
        fin_w.ovf    = 1'b1;
        fin_w.result = fxq_pkg::RAW_MAX;
      end else if (dv_side.neg && qm_w > QW'(fxq_pkg::RAW_MIN)) begin
        fin_w.ovf    = 1'b1;
        fin_w.result = fxq_pkg::RAW_MIN;
      end else begin
        fin_w.result = dv_side.neg ? (32'd0 - qm_w[31:0]) : qm_w[31:0];
      end
    end
  end

  // Output register.
  logic           out_v_r;
  fxq_pkg::side_t out_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_side_r <= fin_w;
    end
  end

  assign out_valid          = out_v_r;
  assign out_result_raw     = out_side_r.result;
  assign out_a_less         = out_side_r.less;
  assign out_a_equal        = out_side_r.equal;
  assign out_a_greater      = out_side_r.greater;
  assign out_divide_by_zero = out_side_r.dz;
  assign out_overflow       = out_side_r.ovf;

  // Exactly one compare flag describes every result beat.
  `FXQ_ASSERT(a_flags_onehot, out_valid |-> $onehot({out_a_less, out_a_equal, out_a_greater}), "compare flags not one-hot")
  // A division by zero never saturates and always returns zero.
  `FXQ_ASSERT(a_dz_zero, (out_valid && out_divide_by_zero) |-> (!out_overflow && out_result_raw == 32'sd0), "bad divide by zero result")
  // A request beat taken into the pipeline appears in the first stage.
  `FXQ_ASSERT(a_s1_load, (in_valid && !in_stall) |=> s1_v_r, "accepted beat lost at entry")
  // The divide flag is set only for real divisions, never with a zero divisor.
  `FXQ_ASSERT(a_div_side, (dv_valid && dv_side.is_div) |-> !dv_side.dz, "divide flags clash")

endmodule
